/* rtl/fra_pkg.sv */
package fra_pkg;

   localparam int unsigned KIND_W   = 2;
   localparam int unsigned HANDLE_W = 6;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC     = 2'd0,
      KIND_TRY_ALLOC = 2'd1,
      KIND_FREE      = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_EMPTY      = 2'd1,
      ST_NOT_IN_USE = 2'd2,
      ST_EXHAUSTED  = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/fra_req_if.sv */
interface fra_req_if import fra_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [HANDLE_W-1:0] handle_in;

   modport source (output valid, output kind, output handle_in, input ready);
   modport sink (input valid, input kind, input handle_in, output ready);
endinterface

/* rtl/fra_rsp_if.sv */
interface fra_rsp_if import fra_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] handle_out;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output handle_out, output status, input ready);
   modport sink (input valid, input handle_out, input status, output ready);
endinterface

/* rtl/fra_ram.sv */
module fra_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

/* rtl/fra_ctrl.sv */
module fra_ctrl import fra_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait for room in the output register
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_EXEC: begin
            cmd.execute = sts.out_free;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/fra_datapath.sv */
module fra_datapath import fra_pkg::*; #(
   parameter int unsigned POOL_SIZE = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       sts,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [HANDLE_W-1:0] req_handle_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int unsigned HW    = $clog2(POOL_SIZE);
   localparam int unsigned CW    = $clog2(POOL_SIZE + 1);
   localparam int unsigned CMP_W = CW + HANDLE_W;

   localparam logic [HW-1:0] LAST_POS = HW'(POOL_SIZE - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(POOL_SIZE);

   kind_type            kind_ff;
   logic [HANDLE_W-1:0] hin_ff;
   logic [HW-1:0]       head_ff, head_in;
   logic [HW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       created_ff, created_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic [HW-1:0] q_rd_data;
   logic          map_rd_data;
   logic          map_wr_en;
   logic [HW-1:0] map_wr_addr;
   logic          map_wr_data;
   logic          q_wr_en;

   logic          do_pop, do_create, do_release;
   logic          queue_nonempty, can_create, is_used;
   logic [HW-1:0] res_handle;
   status_type    res_status;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_type'(req_kind);
         hin_ff  <= req_handle_in;
      end
   end

   fra_ram #(.WIDTH(HW), .DEPTH(POOL_SIZE)) u_free_queue (
      .clock      (clock),
      .wr_en      (q_wr_en),
      .wr_addr    (tail_ff),
      .wr_data    (HW'(hin_ff)),
      .rd_en      (cmd.capture),
      .rd_addr    (head_ff),
      .rd_data_ff (q_rd_data)
   );

   // entries at or above created_ff were never written and read as free
   fra_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_in_use_map (
      .clock      (clock),
      .wr_en      (map_wr_en),
      .wr_addr    (map_wr_addr),
      .wr_data    (map_wr_data),
      .rd_en      (cmd.capture),
      .rd_addr    (HW'(req_handle_in)),
      .rd_data_ff (map_rd_data)
   );

   assign queue_nonempty = (count_ff != '0);
   assign can_create     = (created_ff != FULL_CNT);
   assign is_used        = (CMP_W'(hin_ff) < CMP_W'(created_ff)) && map_rd_data;

   always_comb begin
      do_pop     = 1'b0;
      do_create  = 1'b0;
      do_release = 1'b0;
      res_handle = '0;
      res_status = ST_EMPTY;
      unique case (kind_ff)
         KIND_ALLOC: begin
            if (queue_nonempty) begin
               do_pop     = 1'b1;
               res_handle = q_rd_data;
               res_status = ST_OK;
            end else if (can_create) begin
               do_create  = 1'b1;
               res_handle = HW'(created_ff);
               res_status = ST_OK;
            end else begin
               res_status = ST_EXHAUSTED;
            end
         end
         KIND_TRY_ALLOC: begin
            if (queue_nonempty) begin
               do_pop     = 1'b1;
               res_handle = q_rd_data;
               res_status = ST_OK;
            end
         end
         KIND_FREE: begin
            if (is_used) begin
               do_release = 1'b1;
               res_status = ST_OK;
            end else begin
               res_status = ST_NOT_IN_USE;
            end
         end
         default: res_status = ST_EMPTY;
      endcase
   end

   assign map_wr_en   = cmd.execute && (do_pop || do_create || do_release);
   assign map_wr_data = !do_release;
   assign q_wr_en     = cmd.execute && do_release && (count_ff != FULL_CNT);

   always_comb begin
      priority if (do_pop) begin
         map_wr_addr = q_rd_data;
      end else if (do_create) begin
         map_wr_addr = HW'(created_ff);
      end else begin
         map_wr_addr = HW'(hin_ff);
      end
   end

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      created_in = created_ff;
      if (cmd.execute && do_pop) begin
         head_in  = (head_ff == LAST_POS) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (q_wr_en) begin
         tail_in  = (tail_ff == LAST_POS) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (cmd.execute && do_create) begin
         created_in = created_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.execute) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = HANDLE_W'(res_handle);
         rsp_status_in = res_status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         created_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         created_ff   <= created_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

/* rtl/fifo_reuse_handle_allocator_unit.sv */
// Handle pool allocator with first-in first-out reuse of freed handles. Each request
// (allocate, try-allocate, free) gives exactly one response with a handle and a status.
// A request passes through two states: the accept state reads the free queue RAM at its head
// and the in-use bitmap RAM at the request's handle, and the execute state resolves the request,
// writes both RAMs back and loads the output register. The next request is accepted only once
// the controller is back in idle, so no request is taken while one is in execution, and
// a response held by the sink stalls the execute state. No clearing pass runs
// after reset: handles at or above the created count read as not in use.
module fifo_reuse_handle_allocator_unit import fra_pkg::*; #(
   parameter int unsigned POOL_SIZE = 64
) (
   input  logic clock,
   input  logic reset,
   fra_req_if.sink   req_ch,
   fra_rsp_if.source rsp_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   fra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fra_datapath #(.POOL_SIZE(POOL_SIZE)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_ch.kind),
      .req_handle_in  (req_ch.handle_in),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_handle_out (rsp_ch.handle_out),
      .rsp_status     (rsp_ch.status)
   );

endmodule

/* rtl/fra_checker.sv */
module fra_checker import fra_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [HANDLE_W-1:0] rsp_handle_out,
   input logic [STATUS_W-1:0] rsp_status
);

   // no response pending right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request at a time: ready drops after each transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   // failed requests, rejected frees among them, report handle zero
   a_zero_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_handle_out == '0))
      else $error("nonzero handle on failed request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_handle_out) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind fifo_reuse_handle_allocator_unit fra_checker u_fra_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_handle_out (rsp_ch.handle_out),
   .rsp_status     (rsp_ch.status)
);

/* tb/fifo_reuse_handle_allocator_unit_tb.sv */
`timescale 1ns / 1ps

module fifo_reuse_handle_allocator_unit_tb import fra_pkg::*; ();

   localparam int POOL          = 64;
   localparam int RANDOM_ITEMS  = 700;
   localparam int STALL_LIMIT   = 200;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PLAN_ROWS     = 17;

   // kind code with no meaning, answered as an empty try
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      status_type          status;
   } grant_type;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      bit                  typed;
      grant_type           grant;
   } plan_row_type;

   logic clock;
   logic reset;

   fra_req_if req_if ();
   fra_rsp_if rsp_if ();

   fifo_reuse_handle_allocator_unit #(
      .POOL_SIZE (POOL)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // directed requests; typed rows carry a grant that is plain to see
   plan_row_type plan [PLAN_ROWS] = '{
      '{KIND_TRY_ALLOC, 6'd0,  1'b1, '{6'd0, ST_EMPTY}},
      '{KIND_FREE,      6'd0,  1'b1, '{6'd0, ST_NOT_IN_USE}},
      '{KIND_FREE,      6'd63, 1'b1, '{6'd0, ST_NOT_IN_USE}},
      '{KIND_NONE,      6'd63, 1'b1, '{6'd0, ST_EMPTY}},
      '{KIND_ALLOC,     6'd0,  1'b1, '{6'd0, ST_OK}},
      '{KIND_ALLOC,     6'd63, 1'b1, '{6'd1, ST_OK}},
      '{KIND_FREE,      6'd1,  1'b1, '{6'd0, ST_OK}},
      '{KIND_FREE,      6'd1,  1'b1, '{6'd0, ST_NOT_IN_USE}},
      '{KIND_FREE,      6'd0,  1'b0, '{6'd0, ST_OK}},
      '{KIND_ALLOC,     6'd21, 1'b0, '{6'd0, ST_OK}},
      '{KIND_TRY_ALLOC, 6'd42, 1'b0, '{6'd0, ST_OK}},
      '{KIND_TRY_ALLOC, 6'd0,  1'b1, '{6'd0, ST_EMPTY}},
      '{KIND_FREE,      6'd63, 1'b1, '{6'd0, ST_NOT_IN_USE}},
      '{KIND_ALLOC,     6'd42, 1'b0, '{6'd0, ST_OK}},
      '{KIND_FREE,      6'd2,  1'b0, '{6'd0, ST_OK}},
      '{KIND_NONE,      6'd0,  1'b1, '{6'd0, ST_EMPTY}},
      '{KIND_TRY_ALLOC, 6'd21, 1'b0, '{6'd0, ST_OK}}
   };

   // allocator state as predicted
   logic [HANDLE_W-1:0] free_fifo [POOL];
   int                  fifo_head;
   int                  fifo_tail;
   int                  fifo_count;
   bit [POOL-1:0]       in_use;
   int                  created_cnt;

   grant_type pending_grants [$];

   int  error_count;
   int  sent_count;
   int  got_count;
   int  idle_cycles;
   bit  no_stall;
   int  n_reused;
   int  n_freed;
   int  n_exhausted;
   int  n_empty;
   int  n_rejected;

   always #10 clock = ~clock;

   function automatic grant_type predict_grant(input logic [KIND_W-1:0] k,
                                               input logic [HANDLE_W-1:0] h);
      grant_type g;
      g.handle = '0;
      g.status = ST_EMPTY;
      case (k)
         KIND_ALLOC, KIND_TRY_ALLOC: begin
            if (fifo_count != 0) begin
               g.handle   = free_fifo[fifo_head];
               g.status   = ST_OK;
               fifo_head  = (fifo_head + 1) % POOL;
               fifo_count--;
               in_use[g.handle] = 1'b1;
               n_reused++;
            end else if (k == KIND_TRY_ALLOC) begin
               n_empty++;
            end else if (created_cnt < POOL) begin
               g.handle = created_cnt[HANDLE_W-1:0];
               g.status = ST_OK;
               in_use[created_cnt] = 1'b1;
               created_cnt++;
            end else begin
               g.status = ST_EXHAUSTED;
               n_exhausted++;
            end
         end
         KIND_FREE: begin
            if (!in_use[h]) begin
               g.status = ST_NOT_IN_USE;
               n_rejected++;
            end else begin
               in_use[h] = 1'b0;
               g.status  = ST_OK;
               if (fifo_count < POOL) begin
                  free_fifo[fifo_tail] = h;
                  fifo_tail = (fifo_tail + 1) % POOL;
                  fifo_count++;
               end
               n_freed++;
            end
         end
         default: begin
            g.status = ST_EMPTY;
         end
      endcase
      return g;
   endfunction

   function automatic int draw_gap();
      return no_stall ? 0 : int'($urandom_range(0, 4));
   endfunction

   // mostly a handle that is live, so that frees actually feed the queue
   function automatic logic [HANDLE_W-1:0] pick_free_handle();
      int start;
      int idx;
      start = int'($urandom_range(0, POOL - 1));
      if (in_use != '0 && $urandom_range(0, 9) < 8) begin
         for (int i = 0; i < POOL; i++) begin
            idx = (start + i) % POOL;
            if (in_use[idx]) return idx[HANDLE_W-1:0];
         end
      end
      return HANDLE_W'($urandom_range(0, POOL - 1));
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_request(input logic [KIND_W-1:0] k, input logic [HANDLE_W-1:0] h,
                               input bit typed, input grant_type typed_grant);
      int        gap;
      grant_type g;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.kind      <= k;
      req_if.handle_in <= h;
      do @(posedge clock); while (!req_if.ready);
      g = predict_grant(k, h);
      pending_grants.push_back(typed ? typed_grant : g);
      sent_count++;
      @(negedge clock);
   endtask

   // response side
   initial begin
      grant_type exp_grant;
      int        gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got_count++;
         if (pending_grants.size() == 0) begin
            $display("%0t: response with nothing outstanding: handle %0d status %0d",
                     $time, rsp_if.handle_out, rsp_if.status);
            error_count++;
         end else begin
            exp_grant = pending_grants.pop_front();
            if (rsp_if.handle_out !== exp_grant.handle) begin
               $display("%0t: handle_out expected %0d actual %0d", $time,
                        exp_grant.handle, rsp_if.handle_out);
               error_count++;
            end
            if (rsp_if.status !== exp_grant.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_grant.status, rsp_if.status);
               error_count++;
            end
         end
         @(negedge clock);
      end
   end

   // cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [KIND_W-1:0]   k;
      logic [HANDLE_W-1:0] h;
      bit                  fill_phase;
      int                  phase_left;
      int                  r;
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.kind      = KIND_ALLOC;
      req_if.handle_in = '0;
      error_count      = 0;
      sent_count       = 0;
      got_count        = 0;
      idle_cycles      = 0;
      no_stall         = 1'b0;
      n_reused         = 0;
      n_freed          = 0;
      n_exhausted      = 0;
      n_empty          = 0;
      n_rejected       = 0;
      fifo_head        = 0;
      fifo_tail        = 0;
      fifo_count       = 0;
      in_use           = '0;
      created_cnt      = 0;
      foreach (free_fifo[i]) free_fifo[i] = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         send_request(plan[i].kind, plan[i].handle, plan[i].typed, plan[i].grant);
      end

      // alternate between filling the pool toward exhaustion and draining it
      fill_phase = 1'b1;
      phase_left = $urandom_range(110, 170);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            fill_phase = !fill_phase;
            phase_left = fill_phase ? $urandom_range(110, 170) : $urandom_range(50, 100);
         end
         phase_left--;
         if (n % 32 == 0) no_stall = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (fill_phase) begin
            k = (r < 70) ? KIND_ALLOC : (r < 85) ? KIND_TRY_ALLOC : (r < 95) ? KIND_FREE
                                                                          : KIND_NONE;
         end else begin
            k = (r < 20) ? KIND_ALLOC : (r < 30) ? KIND_TRY_ALLOC : (r < 95) ? KIND_FREE
                                                                          : KIND_NONE;
         end
         h = (k == KIND_FREE) ? pick_free_handle() : HANDLE_W'($urandom_range(0, POOL - 1));
         send_request(k, h, 1'b0, '0);
      end
      req_if.valid <= 1'b0;

      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d responses: %0d handles created, %0d reused",
               sent_count, got_count, created_cnt, n_reused);
      $display("frees %0d ok / %0d not in use, %0d exhausted, %0d empty tries",
               n_freed, n_rejected, n_exhausted, n_empty);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
